@@ design/date_add_days_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the date adder, included by dad_ctrl.
// ----------------------------------------------------------------------------
`ifndef DATE_ADD_DAYS_ASSERT_SVH
`define DATE_ADD_DAYS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DAD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dad_pkg.sv @@
// ----------------------------------------------------------------------------
// dad_pkg
// Widths, calendar constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dad_pkg;

  localparam int unsigned DAY_W     = 5;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 24;

  // Month codes that matter to the day rollover rule.
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W:0]   MONTH_MAX = 5'd12;

  localparam logic [DAY_W:0] DAYS_FEB_LEAP = 6'd29;
  localparam logic [DAY_W:0] DAYS_FEB      = 6'd28;
  localparam logic [DAY_W:0] DAYS_SHORT    = 6'd30;
  localparam logic [DAY_W:0] DAYS_LONG     = 6'd31;

  // floor(y / 100) = (y * 5243) >> 19, exact for every 14-bit year.
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned QUOT_W       = 8;
  localparam logic [YEAR_W-1:0] CENTURY = 14'd100;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } dad_cmd_t;

  typedef struct packed {
    logic count_zero;
  } dad_sts_t;

endpackage

`default_nettype wire

@@ design/date_add_days.sv @@
// ----------------------------------------------------------------------------
// date_add_days
// Gregorian date advance by a day count.
// ----------------------------------------------------------------------------
// Usage: a request on the slave stream carries a start date and a day count;
// the block steps the date forward one day per clock and returns the date it
// reaches as one result on the master stream.
// One request is worked on at a time. s_axis_tready_o is high only while the
// block is idle. After a request is accepted, the leap-year pipeline (a
// multiply by the reciprocal of 100 and a remainder check) settles, the step
// logic advances the date through the day count, and the date it reaches is
// written to the result register once that register is free. The block is
// idle again in the same cycle that the result becomes valid.
// The result sits in its own register, so a new request is accepted while a
// finished result waits for m_axis_tready_i. If the receiver stalls long
// enough for the next request to finish too, that request holds in its last
// state until the result register frees.
// Reset clears the sequencer and the result valid flag; the block then waits
// idle with s_axis_tready_o high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module date_add_days (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output      logic                          s_axis_tready_o,
  // start_day[4:0], start_month[8:5], start_year[22:9], day_count[38:23], zero[39]
  input  wire logic [dad_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  output      logic                          m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // end_day[4:0], end_month[8:5], end_year[22:9], zero[23]
  output      logic [dad_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  dad_pkg::dad_cmd_t cmd;
  dad_pkg::dad_sts_t sts;

  dad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dad_datapath u_datapath (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .req_data_i (s_axis_tdata_i),
    .sts_o      (sts),
    .res_data_o (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

@@ design/dad_datapath.sv @@
// ----------------------------------------------------------------------------
// dad_datapath
// Working date registers, one-day step logic, leap-year pipeline and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dad_datapath (
  input  wire logic                            clk_i,
  input  wire dad_pkg::dad_cmd_t               cmd_i,
  input  wire logic [dad_pkg::S_TDATA_W-1:0]   req_data_i,
  output      dad_pkg::dad_sts_t               sts_o,
  output      logic [dad_pkg::M_TDATA_W-1:0]   res_data_o
);

  logic [dad_pkg::DAY_W-1:0]   day_q,   day_d;
  logic [dad_pkg::MONTH_W-1:0] month_q, month_d;
  logic [dad_pkg::YEAR_W-1:0]  year_q,  year_d;
  logic [dad_pkg::COUNT_W-1:0] left_q,  left_d;
  logic [dad_pkg::M_TDATA_W-1:0] res_q;

  // Leap-year pipeline, recomputed every cycle from the working year.
  logic [26:0]                 prod;
  logic [dad_pkg::QUOT_W-1:0]  quot_q;
  logic [dad_pkg::YEAR_W-1:0]  yr_q;
  logic [dad_pkg::YEAR_W-1:0]  rem;
  logic                        leap_q, leap_d;

  logic [dad_pkg::DAY_W:0]     next_day;
  logic [dad_pkg::MONTH_W:0]   next_month;
  logic                        short_month;
  logic                        roll;

  assign prod = 27'(year_q) * 27'(dad_pkg::DIV100_MUL);
  assign rem  = yr_q - 14'(quot_q) * dad_pkg::CENTURY;
  assign leap_d = (yr_q[1:0] == 2'b00) && ((rem != '0) || (quot_q[1:0] == 2'b00));

  always_ff @(posedge clk_i) begin
    quot_q <= prod[dad_pkg::DIV100_SHIFT +: dad_pkg::QUOT_W];
    yr_q   <= year_q;
    leap_q <= leap_d;
  end

  always_comb begin
    next_day    = {1'b0, day_q} + 6'd1;
    short_month = (month_q == dad_pkg::MONTH_APR) || (month_q == dad_pkg::MONTH_JUN) ||
                  (month_q == dad_pkg::MONTH_SEP) || (month_q == dad_pkg::MONTH_NOV);
    roll = (next_day > dad_pkg::DAYS_LONG);
    if (month_q == dad_pkg::MONTH_FEB) begin
      roll = roll || (next_day > dad_pkg::DAYS_FEB_LEAP) ||
             ((next_day > dad_pkg::DAYS_FEB) && !leap_q);
    end else if (short_month) begin
      roll = roll || (next_day > dad_pkg::DAYS_SHORT);
    end
    next_month = {1'b0, month_q} + {4'd0, roll};

    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    left_d  = left_q;
    if (cmd_i.load) begin
      day_d   = req_data_i[4:0];
      month_d = req_data_i[8:5];
      year_d  = req_data_i[22:9];
      left_d  = req_data_i[38:23];
    end else if (cmd_i.step) begin
      // A day of 32 always rolls, so the low five bits suffice otherwise.
      day_d  = roll ? 5'd1 : next_day[dad_pkg::DAY_W-1:0];
      left_d = left_q - 16'd1;
      if (next_month > dad_pkg::MONTH_MAX) begin
        month_d = dad_pkg::MONTH_JAN;
        year_d  = year_q + 14'd1;
      end else begin
        month_d = next_month[dad_pkg::MONTH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    day_q   <= day_d;
    month_q <= month_d;
    year_q  <= year_d;
    left_q  <= left_d;
    if (cmd_i.emit) begin
      res_q <= {1'b0, year_q, month_q, day_q};
    end
  end

  assign sts_o.count_zero = (left_q == '0);
  assign res_data_o       = res_q;

endmodule

`default_nettype wire

@@ design/dad_ctrl.sv @@
// ----------------------------------------------------------------------------
// dad_ctrl
// Sequencer for the date adder: load, leap pipeline settle, day stepping and
// hand-off to the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "date_add_days_assert.svh"

module dad_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  output      logic              s_tready_o,
  output      logic              m_tvalid_o,
  input  wire logic              m_tready_i,
  input  wire dad_pkg::dad_sts_t sts_i,
  output      dad_pkg::dad_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PREP0 = 2'd1;
  localparam logic [1:0] ST_PREP1 = 2'd2;
  localparam logic [1:0] ST_RUN   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       valid_q, valid_d;
  logic       out_free;

  assign out_free = !valid_q || m_tready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    cmd_o.emit = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP0;
        end
      end
      // The leap flag trails the working year through quot_q/yr_q and then leap_q.
      ST_PREP0: state_d = ST_PREP1;
      ST_PREP1: state_d = ST_RUN;
      ST_RUN: begin
        if (!sts_i.count_zero) begin
          cmd_o.step = 1'b1;
        end else if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_o.emit) begin
      valid_d = 1'b1;
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = valid_q;

  `DAD_ASSERT_NEXT(a_accept_prep, s_tvalid_i && s_tready_o, state_q == ST_PREP0, "accept did not start a run")
  `DAD_ASSERT_SAME(a_emit_free, cmd_o.emit, !m_tvalid_o || m_tready_i, "result overwrote a pending one")
  `DAD_ASSERT_SAME(a_step_count, cmd_o.step, !sts_i.count_zero, "step with no days left")
  `DAD_ASSERT_NEXT(a_emit_valid, cmd_o.emit, m_tvalid_o && (state_q == ST_IDLE), "emit lost")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Gregorian date adder.
// ----------------------------------------------------------------------------
// Requests carry a start date and a day count on the slave stream. A local
// calendar walker steps each accepted request one day at a time and queues
// the date it lands on. Every result from the master stream is then checked
// field by field against the oldest queued date. Directed edge dates come
// first, then random requests under several idle and stall mixes. One phase
// holds the receiver off long enough to back the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int unsigned IDLE_LIMIT  = 300000;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned TAIL_CYCLES = 16;

  // The last member sits in the lowest bits, matching the tdata layout.
  typedef struct packed {
    logic [dad_pkg::COUNT_W-1:0] day_count;
    logic [dad_pkg::YEAR_W-1:0]  start_year;
    logic [dad_pkg::MONTH_W-1:0] start_month;
    logic [dad_pkg::DAY_W-1:0]   start_day;
  } date_req_t;

  typedef struct packed {
    logic [dad_pkg::YEAR_W-1:0]  end_year;
    logic [dad_pkg::MONTH_W-1:0] end_month;
    logic [dad_pkg::DAY_W-1:0]   end_day;
  } date_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [dad_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [dad_pkg::M_TDATA_W-1:0] m_axis_tdata;

  date_req_t pending_reqs[$];
  date_t     expected_dates[$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned reqs_queued     = 0;
  int unsigned reqs_taken      = 0;
  int unsigned dates_checked   = 0;
  int unsigned mismatch_count  = 0;
  int unsigned idle_cycles     = 0;
  int unsigned hold_left       = 0;
  logic        hold_arm        = 1'b0;
  logic        hold_done       = 1'b0;
  logic        req_fire        = 1'b0;

  date_add_days dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Walks the calendar one day per iteration. Day and month carry an extra
  // bit so that out-of-range start values never wrap inside a step.
  function automatic date_t advance_date(date_req_t req);
    logic [dad_pkg::DAY_W:0]      day;
    logic [dad_pkg::MONTH_W:0]    month;
    logic [dad_pkg::YEAR_W-1:0]   year;
    logic                         leap;
    logic                         roll;
    date_t                        lands;
    day   = {1'b0, req.start_day};
    month = {1'b0, req.start_month};
    year  = req.start_year;
    for (int unsigned n = 0; n < req.day_count; n++) begin
      leap = (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
      day  = day + 1'b1;
      roll = 1'b0;
      if (month == dad_pkg::MONTH_FEB) begin
        if (day > dad_pkg::DAYS_FEB_LEAP || (day > dad_pkg::DAYS_FEB && !leap)) begin
          roll = 1'b1;
        end
      end else if (month == dad_pkg::MONTH_APR || month == dad_pkg::MONTH_JUN ||
                   month == dad_pkg::MONTH_SEP || month == dad_pkg::MONTH_NOV) begin
        if (day > dad_pkg::DAYS_SHORT) begin
          roll = 1'b1;
        end
      end
      if (day > dad_pkg::DAYS_LONG) begin
        roll = 1'b1;
      end
      if (roll) begin
        day   = 6'd1;
        month = month + 1'b1;
      end
      if (month > dad_pkg::MONTH_MAX) begin
        month = {1'b0, dad_pkg::MONTH_JAN};
        year  = year + 1'b1;
      end
    end
    lands.end_day   = day[dad_pkg::DAY_W-1:0];
    lands.end_month = month[dad_pkg::MONTH_W-1:0];
    lands.end_year  = year;
    return lands;
  endfunction

  function automatic date_req_t make_req(int unsigned day, int unsigned month,
                                         int unsigned year, int unsigned count);
    date_req_t req;
    req.start_day   = 5'(day);
    req.start_month = 4'(month);
    req.start_year  = 14'(year);
    req.day_count   = 16'(count);
    return req;
  endfunction

  // Mostly valid dates and short counts; now and then out-of-range fields,
  // years near the wrap point and long counts.
  function automatic date_req_t rand_date_req(int unsigned max_count);
    date_req_t   req;
    int unsigned pick;
    req.start_day   = 5'(($urandom_range(99) < 90) ? $urandom_range(31, 1) :
                                                     $urandom_range(31));
    req.start_month = 4'(($urandom_range(99) < 90) ? $urandom_range(12, 1) :
                                                     $urandom_range(15));
    req.start_year  = 14'(($urandom_range(99) < 90) ? $urandom_range(9999) :
                                                      $urandom_range(16383, 16300));
    pick = $urandom_range(99);
    if (pick < 70) begin
      req.day_count = 16'($urandom_range(400));
    end else if (pick < 90) begin
      req.day_count = 16'($urandom_range(4000));
    end else if (pick < 97) begin
      req.day_count = 16'($urandom_range(20000));
    end else begin
      req.day_count = 16'($urandom_range(65535));
    end
    if (req.day_count > max_count) begin
      req.day_count = 16'(req.day_count % (max_count + 1));
    end
    return req;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH @%0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_random(int unsigned n, int unsigned max_count);
    repeat (n) begin
      pending_reqs.push_back(rand_date_req(max_count));
      reqs_queued++;
    end
  endtask

  // Returns at a falling edge once every queued request has its result back.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (reqs_taken != reqs_queued || expected_dates.size() != 0);
  endtask

  // Sender: a new request is offered only once the previous one was taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_fire) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        s_axis_tdata  <= {{(dad_pkg::S_TDATA_W - $bits(date_req_t)){1'b0}},
                          pending_reqs.pop_front()};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(negedge clk) begin
    if (!rst_n) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    date_t got;
    date_t want;
    req_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_n) begin
      // Results are handled before new requests so a request accepted in
      // the same cycle can never match the result going out.
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(date_t)-1:0];
        dates_checked++;
        if (expected_dates.size() == 0) begin
          report_mismatch("result with no request pending", got, 0);
        end else begin
          want = expected_dates.pop_front();
          if (got.end_day != want.end_day) begin
            report_mismatch("end_day", got.end_day, want.end_day);
          end
          if (got.end_month != want.end_month) begin
            report_mismatch("end_month", got.end_month, want.end_month);
          end
          if (got.end_year != want.end_year) begin
            report_mismatch("end_year", got.end_year, want.end_year);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_dates.push_back(advance_date(s_axis_tdata[$bits(date_req_t)-1:0]));
        reqs_taken++;
      end
    end
  end

  // Watchdog on cycles in which neither stream moves anything.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no traffic for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Edge dates: zero counts, February in every kind of year, days and
    // months out of range, year wrap and the longest count.
    pending_reqs.push_back(make_req(1, 1, 2000, 0));
    pending_reqs.push_back(make_req(31, 15, 16383, 0));
    pending_reqs.push_back(make_req(0, 0, 0, 0));
    pending_reqs.push_back(make_req(28, 2, 2023, 1));
    pending_reqs.push_back(make_req(28, 2, 2024, 1));
    pending_reqs.push_back(make_req(28, 2, 1900, 1));
    pending_reqs.push_back(make_req(29, 2, 1900, 1));
    pending_reqs.push_back(make_req(28, 2, 2000, 1));
    pending_reqs.push_back(make_req(30, 2, 2021, 1));
    pending_reqs.push_back(make_req(31, 4, 2021, 1));
    pending_reqs.push_back(make_req(30, 11, 2021, 1));
    pending_reqs.push_back(make_req(31, 1, 2021, 1));
    pending_reqs.push_back(make_req(15, 9, 2021, 16));
    pending_reqs.push_back(make_req(0, 6, 2021, 1));
    pending_reqs.push_back(make_req(31, 0, 2021, 1));
    pending_reqs.push_back(make_req(5, 13, 2021, 1));
    pending_reqs.push_back(make_req(10, 15, 9999, 3));
    pending_reqs.push_back(make_req(31, 12, 16383, 1));
    pending_reqs.push_back(make_req(28, 2, 0, 1));
    pending_reqs.push_back(make_req(1, 1, 2024, 366));
    pending_reqs.push_back(make_req(1, 3, 2023, 40000));
    pending_reqs.push_back(make_req(31, 12, 9999, 65535));
    reqs_queued += 22;
    queue_random(20, 65535);
    wait_drained();

    @(posedge clk);
    sender_idle_pct = 56;
    queue_random(22, 65535);
    wait_drained();

    @(posedge clk);
    sender_idle_pct = 0;
    recv_stall_pct  = 56;
    queue_random(22, 65535);
    wait_drained();

    @(posedge clk);
    sender_idle_pct = 17;
    recv_stall_pct  = 17;
    queue_random(22, 65535);
    wait_drained();

    // Short requests against a long receiver hold-off: the result register
    // and the working registers both fill, and the input must stall.
    @(posedge clk);
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_arm        = 1'b1;
    queue_random(8, 50);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d date requests, directed edge dates then random, %0d results checked.",
             reqs_taken, dates_checked);
    $display("Idle mixes: none, sender 56%%, receiver 56%%, both 17%%, one long receiver hold-off.");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
